// ===== hdl/pflru_pkg.sv =====
`timescale 1ns / 1ps
package pflru_pkg;
  localparam int NUM_PROCS_DEF  = 4;
  localparam int NUM_PAGES_DEF  = 32;
  localparam int NUM_FRAMES_DEF = 16;
  localparam logic [31:0] NEVER_USED = 32'hFFFF_FFFF;
  localparam logic [31:0] CLOCK_TOP  = 32'hFFFF_FFFE;
  localparam logic [15:0] CNT_MAX    = 16'hFFFF;

  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_FAULT   = 2'd1,
    OUT_ILLEGAL = 2'd2,
    OUT_FINISH  = 2'd3
  } outcome_t;

  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DECIDE,
    ST_REL_RD,
    ST_REL_WR,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EVICT,
    ST_CLEAR,
    ST_OUT
  } state_t;
endpackage

// ===== hdl/page_fault_lru_frame_manager.sv =====
`timescale 1ns / 1ps
// Demand-paging frame manager with per-process LRU replacement. Page tables and
// use stamps live in two single-port-write synchronous memories. After reset a
// clearing pass over all NUM_PROCS*NUM_PAGES entries runs before the first word
// is taken. A hit or a fault with a free frame is settled on lookup; an
// illegal access or a finish walks all pages of the process and frees their
// frames; a fault with no free frame scans the pages below the limit for the
// least recently used valid page. One word is in flight at a time; the result
// word is held until taken.
module page_fault_lru_frame_manager #(
  parameter int NUM_PROCS  = pflru_pkg::NUM_PROCS_DEF,
  parameter int NUM_PAGES  = pflru_pkg::NUM_PAGES_DEF,
  parameter int NUM_FRAMES = pflru_pkg::NUM_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // process_slot[1:0], page[6:2], page_limit[12:7]
  input  logic        in_tuser,  // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // outcome, frame, frame_valid, fault_total, illegal_total
  output logic        out_tuser
);
  logic [1:0]  outcome;
  logic [3:0]  frame;
  logic        frame_valid;
  logic [15:0] fault_total, illegal_total;

  pflru_ctrl #(.NUM_PROCS(NUM_PROCS), .NUM_PAGES(NUM_PAGES), .NUM_FRAMES(NUM_FRAMES)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_process_slot(in_tdata[1:0]), .in_req_type(in_tuser),
    .in_page(in_tdata[6:2]), .in_page_limit(in_tdata[12:7]),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_outcome(outcome), .out_frame(frame), .out_frame_valid(frame_valid),
    .out_fault_total(fault_total), .out_illegal_total(illegal_total)
  );

  assign out_tdata = {1'b0, illegal_total, fault_total, frame_valid, frame, outcome};
  assign out_tuser = 1'b0;
endmodule

// ===== hdl/pflru_frames.sv =====
`timescale 1ns / 1ps
module pflru_frames #(
  parameter int NUM_FRAMES = pflru_pkg::NUM_FRAMES_DEF,
  parameter int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          free_en,
  input  logic [FW-1:0] free_idx,
  input  logic          take_en,
  output logic          any_free,
  output logic [FW-1:0] low_free
);
  logic [NUM_FRAMES-1:0] free_r;
  logic [NUM_FRAMES-1:0] free_nxt;

  always_comb begin
    free_nxt = free_r;
    if (take_en && any_free) begin
      free_nxt[low_free] = 1'b0;
    end
    if (free_en && (32'(free_idx) < NUM_FRAMES)) begin
      free_nxt[free_idx] = 1'b1;
    end
  end

  always_comb begin
    any_free = 1'b0;
    low_free = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        any_free = 1'b1;
        low_free = FW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '1;
    end else begin
      free_r <= free_nxt;
    end
  end
endmodule

// ===== hdl/pflru_ctrl.sv =====
`timescale 1ns / 1ps
module pflru_ctrl #(
  parameter int NUM_PROCS  = pflru_pkg::NUM_PROCS_DEF,
  parameter int NUM_PAGES  = pflru_pkg::NUM_PAGES_DEF,
  parameter int NUM_FRAMES = pflru_pkg::NUM_FRAMES_DEF,
  parameter int PSW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1,
  parameter int PGW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1,
  parameter int FW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_process_slot,
  input  logic        in_req_type,
  input  logic [4:0]  in_page,
  input  logic [5:0]  in_page_limit,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_outcome,
  output logic [3:0]  out_frame,
  output logic        out_frame_valid,
  output logic [15:0] out_fault_total,
  output logic [15:0] out_illegal_total
);
  localparam int DEPTH = NUM_PROCS * NUM_PAGES;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW = $clog2(NUM_PAGES + 1);
  localparam int EW = FW + 1;

  // map entry: valid bit over frame; last use kept in a second memory
  logic [EW-1:0] map_mem [DEPTH];
  logic [31:0]   use_mem [DEPTH];
  logic [EW-1:0] map_q;
  logic [31:0]   use_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          map_we, use_we;
  logic [EW-1:0] map_wd;
  logic [31:0]   use_wd;

  pflru_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [31:0]   clock_r, clock_nxt;
  logic [15:0]   fcnt_r [NUM_PROCS];
  logic [15:0]   icnt_r [NUM_PROCS];
  logic [PSW-1:0] p_r, p_nxt;
  logic          req_r, req_nxt;
  logic [5:0]    page_r, page_nxt;
  logic [KW-1:0] lim_r, lim_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [31:0]   old_r, old_nxt;
  logic [PGW-1:0] vic_r, vic_nxt;
  logic          found_r, found_nxt;
  logic [FW-1:0] vfr_r, vfr_nxt;
  logic [1:0]    oc_r, oc_nxt;
  logic [3:0]    fr_r, fr_nxt;
  logic          fv_r, fv_nxt;
  logic          f_inc, i_inc;

  logic          free_en, take_en, any_free;
  logic [FW-1:0] free_idx, low_free;

  // victim clear takes the write port in the cycle after evict
  logic          vclr_r;
  logic [AW-1:0] vaddr_r;

  pflru_frames #(.NUM_FRAMES(NUM_FRAMES), .FW(FW)) u_frames (
    .clk(clk), .rst_n(rst_n), .free_en(free_en), .free_idx(free_idx),
    .take_en(take_en), .any_free(any_free), .low_free(low_free)
  );

  function automatic logic [AW-1:0] ent(input logic [PSW-1:0] p, input logic [PGW-1:0] k);
    ent = AW'(32'(p) * NUM_PAGES + 32'(k));
  endfunction

  logic [PSW-1:0] slot_in;
  logic [KW-1:0]  lim_in;
  always_comb begin
    slot_in = PSW'(32'(in_process_slot) % NUM_PROCS);
    lim_in  = (32'(in_page_limit) > NUM_PAGES) ? KW'(NUM_PAGES) : KW'(in_page_limit);
  end

  assign in_tready = (state_r == pflru_pkg::ST_IDLE);
  assign out_tvalid = (state_r == pflru_pkg::ST_OUT);
  assign out_outcome = oc_r;
  assign out_frame = fr_r;
  assign out_frame_valid = fv_r;
  assign out_fault_total = fcnt_r[p_r];
  assign out_illegal_total = icnt_r[p_r];

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    k_nxt = k_r;
    case (state_r)
      pflru_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == DEPTH - 1) state_nxt = pflru_pkg::ST_IDLE;
      end
      pflru_pkg::ST_IDLE: if (in_tvalid) state_nxt = pflru_pkg::ST_LOOK;
      pflru_pkg::ST_LOOK: state_nxt = pflru_pkg::ST_DECIDE;
      pflru_pkg::ST_DECIDE: begin
        k_nxt = '0;
        if (req_r == pflru_pkg::REQ_FINISH) state_nxt = pflru_pkg::ST_REL_RD;
        else if (32'(page_r) < NUM_PAGES && map_q[FW]) state_nxt = pflru_pkg::ST_OUT;
        else if (6'(page_r) >= 6'(lim_r)) state_nxt = pflru_pkg::ST_REL_RD;
        else if (any_free) state_nxt = pflru_pkg::ST_OUT;
        else if (lim_r == '0) state_nxt = pflru_pkg::ST_OUT;
        else state_nxt = pflru_pkg::ST_SCAN_RD;
      end
      pflru_pkg::ST_REL_RD: state_nxt = pflru_pkg::ST_REL_WR;
      pflru_pkg::ST_REL_WR: begin
        k_nxt = k_r + 1'b1;
        state_nxt = (32'(k_r) == NUM_PAGES - 1) ? pflru_pkg::ST_OUT : pflru_pkg::ST_REL_RD;
      end
      pflru_pkg::ST_SCAN_RD: state_nxt = pflru_pkg::ST_SCAN_CMP;
      pflru_pkg::ST_SCAN_CMP: begin
        k_nxt = k_r + 1'b1;
        state_nxt = (k_r + 1'b1 == lim_r) ? pflru_pkg::ST_EVICT : pflru_pkg::ST_SCAN_RD;
      end
      pflru_pkg::ST_EVICT: state_nxt = pflru_pkg::ST_OUT;
      pflru_pkg::ST_OUT: if (out_tready) state_nxt = pflru_pkg::ST_IDLE;
      default: state_nxt = pflru_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    p_nxt = p_r; req_nxt = req_r; page_nxt = page_r; lim_nxt = lim_r;
    clock_nxt = clock_r; old_nxt = old_r; vic_nxt = vic_r; found_nxt = found_r;
    vfr_nxt = vfr_r; oc_nxt = oc_r; fr_nxt = fr_r; fv_nxt = fv_r;
    rd_addr = ent(p_r, PGW'(k_r));
    wr_addr = rd_addr;
    map_we = 1'b0; use_we = 1'b0; map_wd = '0; use_wd = pflru_pkg::NEVER_USED;
    free_en = 1'b0; free_idx = map_q[FW-1:0]; take_en = 1'b0;
    f_inc = 1'b0; i_inc = 1'b0;
    case (state_r)
      pflru_pkg::ST_CLEAR: begin
        wr_addr = clr_r; map_we = 1'b1; use_we = 1'b1;
      end
      pflru_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          p_nxt = slot_in; req_nxt = in_req_type; page_nxt = {1'b0, in_page};
          lim_nxt = lim_in;
          if (clock_r < pflru_pkg::CLOCK_TOP) clock_nxt = clock_r + 32'd1;
          rd_addr = ent(slot_in, PGW'(in_page));
        end
      end
      pflru_pkg::ST_LOOK: begin
        rd_addr = ent(p_r, PGW'(page_r));
      end
      pflru_pkg::ST_DECIDE: begin
        wr_addr = ent(p_r, PGW'(page_r));
        old_nxt = pflru_pkg::NEVER_USED; found_nxt = 1'b0; vic_nxt = '0;
        fr_nxt = '0; fv_nxt = 1'b0;
        if (req_r == pflru_pkg::REQ_FINISH) begin
          oc_nxt = pflru_pkg::OUT_FINISH;
        end else if (32'(page_r) < NUM_PAGES && map_q[FW]) begin
          oc_nxt = pflru_pkg::OUT_HIT; use_we = 1'b1; use_wd = clock_r;
          fr_nxt = 4'(map_q[FW-1:0]); fv_nxt = 1'b1;
        end else if (6'(page_r) >= 6'(lim_r)) begin
          oc_nxt = pflru_pkg::OUT_ILLEGAL; i_inc = 1'b1;
        end else begin
          oc_nxt = pflru_pkg::OUT_FAULT; f_inc = 1'b1;
          if (any_free) begin
            take_en = 1'b1; map_we = 1'b1; use_we = 1'b1;
            map_wd = {1'b1, low_free}; use_wd = clock_r;
            fr_nxt = 4'(low_free); fv_nxt = 1'b1;
          end
        end
      end
      pflru_pkg::ST_REL_WR: begin
        free_en = map_q[FW]; map_we = 1'b1; use_we = 1'b1;
      end
      pflru_pkg::ST_SCAN_CMP: begin
        if (map_q[FW] && use_q < old_r) begin
          old_nxt = use_q; vic_nxt = PGW'(k_r); found_nxt = 1'b1;
          vfr_nxt = map_q[FW-1:0];
        end
      end
      pflru_pkg::ST_EVICT: begin
        if (found_r) begin
          // victim entry is cleared next, new entry written here
          wr_addr = ent(p_r, PGW'(page_r)); map_we = 1'b1; use_we = 1'b1;
          map_wd = {1'b1, vfr_r}; use_wd = clock_r;
          fr_nxt = 4'(vfr_r); fv_nxt = 1'b1;
          rd_addr = ent(p_r, vic_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    map_q <= map_mem[rd_addr];
    use_q <= use_mem[rd_addr];
    if (vclr_r) begin
      map_mem[vaddr_r] <= '0;
      use_mem[vaddr_r] <= pflru_pkg::NEVER_USED;
    end else begin
      if (map_we) map_mem[wr_addr] <= map_wd;
      if (use_we) use_mem[wr_addr] <= use_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pflru_pkg::ST_CLEAR;
      clr_r <= '0;
      clock_r <= '0;
      k_r <= '0;
      vclr_r <= 1'b0;
      for (int i = 0; i < NUM_PROCS; i++) begin
        fcnt_r[i] <= '0;
        icnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      clock_r <= clock_nxt;
      k_r <= k_nxt;
      vclr_r <= (state_r == pflru_pkg::ST_EVICT) && found_r;
      if (f_inc && fcnt_r[p_r] != pflru_pkg::CNT_MAX) fcnt_r[p_r] <= fcnt_r[p_r] + 16'd1;
      if (i_inc && icnt_r[p_r] != pflru_pkg::CNT_MAX) icnt_r[p_r] <= icnt_r[p_r] + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt; req_r <= req_nxt; page_r <= page_nxt; lim_r <= lim_nxt;
    old_r <= old_nxt; vic_r <= vic_nxt; found_r <= found_nxt; vfr_r <= vfr_nxt;
    oc_r <= oc_nxt; fr_r <= fr_nxt; fv_r <= fv_nxt;
    vaddr_r <= ent(p_r, vic_r);
  end
endmodule

// ===== tb/sv/tb_page_fault_lru_frame_manager.sv =====
`timescale 1ns / 1ps
module tb_page_fault_lru_frame_manager;

  localparam int NPROC  = 4;
  localparam int NPAGE  = 32;
  localparam int NFRAME = 16;
  localparam int N_RAND = 550;

  // lowest bits last: outcome sits at the bottom of the word
  typedef struct packed {
    logic [15:0]          illegal_total;
    logic [15:0]          fault_total;
    logic                 frame_valid;
    logic [3:0]           frame;
    pflru_pkg::outcome_t  outcome;
  } page_result_t;

  typedef struct {
    logic         req;
    logic [1:0]   slot;
    logic [4:0]   page;
    logic [5:0]   limit;
    bit           typed;
    page_result_t res;
  } page_req_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [39:0] out_tdata;
  logic out_tuser;

  page_fault_lru_frame_manager uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // page table shadow
  logic        pt_valid [NPROC*NPAGE];
  logic [3:0]  pt_frame [NPROC*NPAGE];
  logic [31:0] pt_stamp [NPROC*NPAGE];
  logic        frm_free [NFRAME];
  logic [31:0] req_clock;
  logic [15:0] faults [NPROC];
  logic [15:0] illegals [NPROC];

  page_result_t expected_q[$];
  int errors = 0;
  bit send_done = 0;
  int words_out = 0;

  function automatic void free_process(int p);
    for (int k = 0; k < NPAGE; k++) begin
      if (pt_valid[p*NPAGE+k]) frm_free[pt_frame[p*NPAGE+k]] = 1;
      pt_valid[p*NPAGE+k] = 0;
      pt_frame[p*NPAGE+k] = 0;
      pt_stamp[p*NPAGE+k] = pflru_pkg::NEVER_USED;
    end
  endfunction

  function automatic page_result_t lru_access(logic req, logic [1:0] slot,
                                              logic [4:0] page, logic [5:0] lim_in);
    page_result_t r;
    int p, lim, e, victim;
    logic [31:0] oldest;
    bit got;
    p = slot % NPROC;
    lim = (lim_in > NPAGE) ? NPAGE : lim_in;
    e = p*NPAGE + page;
    r = '0;
    if (req_clock < pflru_pkg::CLOCK_TOP) req_clock++;
    if (req == pflru_pkg::REQ_FINISH) begin
      free_process(p);
      r.outcome = pflru_pkg::OUT_FINISH;
    end else if (pt_valid[e]) begin
      pt_stamp[e] = req_clock;
      r.outcome = pflru_pkg::OUT_HIT;
      r.frame = pt_frame[e];
      r.frame_valid = 1;
    end else if (page >= lim) begin
      if (illegals[p] != pflru_pkg::CNT_MAX) illegals[p]++;
      free_process(p);
      r.outcome = pflru_pkg::OUT_ILLEGAL;
    end else begin
      if (faults[p] != pflru_pkg::CNT_MAX) faults[p]++;
      r.outcome = pflru_pkg::OUT_FAULT;
      got = 0;
      for (int f = 0; f < NFRAME && !got; f++) begin
        if (frm_free[f]) begin
          frm_free[f] = 0;
          got = 1;
          pt_valid[e] = 1;
          pt_frame[e] = f;
          pt_stamp[e] = req_clock;
          r.frame = f;
          r.frame_valid = 1;
        end
      end
      if (!got) begin
        oldest = pflru_pkg::NEVER_USED;
        victim = -1;
        for (int k = 0; k < lim; k++) begin
          if (pt_valid[p*NPAGE+k] && pt_stamp[p*NPAGE+k] < oldest) begin
            oldest = pt_stamp[p*NPAGE+k];
            victim = p*NPAGE+k;
          end
        end
        if (victim >= 0) begin
          pt_frame[e] = pt_frame[victim];
          pt_valid[e] = 1;
          pt_stamp[e] = req_clock;
          pt_valid[victim] = 0;
          pt_frame[victim] = 0;
          pt_stamp[victim] = pflru_pkg::NEVER_USED;
          r.frame = pt_frame[e];
          r.frame_valid = 1;
        end
      end
    end
    r.fault_total = faults[p];
    r.illegal_total = illegals[p];
    return r;
  endfunction

  function automatic page_result_t mk(pflru_pkg::outcome_t o, int f, int fv, int ft, int it);
    page_result_t r;
    r.outcome = o;
    r.frame = f;
    r.frame_valid = fv;
    r.fault_total = ft;
    r.illegal_total = it;
    return r;
  endfunction

  task automatic send_word(page_req_t w);
    int gap;
    page_result_t pr;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= w.req;
    in_tdata <= {3'b000, w.limit, w.page, w.slot};
    do @(posedge clk); while (!in_tready);
    pr = lru_access(w.req, w.slot, w.page, w.limit);
    expected_q.push_back(w.typed ? w.res : pr);
  endtask

  // sender
  initial begin
    page_req_t dir_tab [25];
    page_req_t w;
    int pick;
    for (int i = 0; i < NPROC*NPAGE; i++) begin
      pt_valid[i] = 0;
      pt_frame[i] = 0;
      pt_stamp[i] = pflru_pkg::NEVER_USED;
    end
    for (int i = 0; i < NFRAME; i++) frm_free[i] = 1;
    for (int i = 0; i < NPROC; i++) begin
      faults[i] = 0;
      illegals[i] = 0;
    end
    req_clock = 0;

    dir_tab[0] = '{pflru_pkg::REQ_ACCESS, 0, 0, 32, 1, mk(pflru_pkg::OUT_FAULT, 0, 1, 1, 0)};
    dir_tab[1] = '{pflru_pkg::REQ_ACCESS, 0, 0, 32, 1, mk(pflru_pkg::OUT_HIT, 0, 1, 1, 0)};
    dir_tab[2] = '{pflru_pkg::REQ_ACCESS, 0, 31, 63, 1, mk(pflru_pkg::OUT_FAULT, 1, 1, 2, 0)};
    dir_tab[3] = '{pflru_pkg::REQ_ACCESS, 0, 5, 0, 1, mk(pflru_pkg::OUT_ILLEGAL, 0, 0, 2, 1)};
    dir_tab[4] = '{pflru_pkg::REQ_ACCESS, 1, 3, 3, 1, mk(pflru_pkg::OUT_ILLEGAL, 0, 0, 0, 1)};
    dir_tab[5] = '{pflru_pkg::REQ_FINISH, 1, 31, 63, 1, mk(pflru_pkg::OUT_FINISH, 0, 0, 0, 1)};
    dir_tab[6] = '{pflru_pkg::REQ_ACCESS, 3, 31, 31, 1, mk(pflru_pkg::OUT_ILLEGAL, 0, 0, 0, 1)};
    // fill every frame from slot 2
    for (int i = 0; i < 16; i++) dir_tab[7+i] = '{pflru_pkg::REQ_ACCESS, 2, i, 32, 0, '0};
    // out-of-limit access from slot 2 that frees its frames, then a fault from slot 3 that takes a free frame
    dir_tab[23] = '{pflru_pkg::REQ_ACCESS, 2, 16, 16, 0, '0};
    dir_tab[24] = '{pflru_pkg::REQ_ACCESS, 3, 0, 1, 0, '0};

    repeat (5) @(posedge clk);
    rst_n <= 1;
    foreach (dir_tab[i]) send_word(dir_tab[i]);

    for (int n = 0; n < N_RAND; n++) begin
      w.typed = 0;
      w.res = '0;
      w.slot = $urandom_range(0, 3);
      w.req = ($urandom_range(0, 24) == 0) ? pflru_pkg::REQ_FINISH : pflru_pkg::REQ_ACCESS;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        w.page = $urandom_range(0, 31);
        w.limit = $urandom_range(0, 63);
      end else begin
        w.page = $urandom_range(0, 11);
        w.limit = $urandom_range(w.page + 1, 32);
        if (pick == 1) w.limit = $urandom_range(0, w.page);
      end
      send_word(w);
    end
    in_tvalid <= 0;
    send_done = 1;
  end

  // receiver with one long hold-off
  initial begin
    int stall;
    bit held;
    page_result_t got, exp_r;
    stall = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = out_tdata[38:0];
        words_out++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word %h", $time, out_tdata);
        end else begin
          exp_r = expected_q.pop_front();
          if (got.outcome !== exp_r.outcome || got.frame !== exp_r.frame ||
              got.frame_valid !== exp_r.frame_valid ||
              got.fault_total !== exp_r.fault_total ||
              got.illegal_total !== exp_r.illegal_total) begin
            errors++;
            $display("%0t: mismatch expected o=%0d f=%0d v=%0d ft=%0d it=%0d", $time,
                     exp_r.outcome, exp_r.frame, exp_r.frame_valid,
                     exp_r.fault_total, exp_r.illegal_total);
            $display("%0t:          actual o=%0d f=%0d v=%0d ft=%0d it=%0d", $time,
                     got.outcome, got.frame, got.frame_valid,
                     got.fault_total, got.illegal_total);
          end
        end
        if (words_out == 120 && !held) begin
          held = 1;
          stall = 600;
        end else if ($urandom_range(0, 3) == 0) begin
          stall = 0;
        end else begin
          stall = $urandom_range(0, 7);
        end
      end
      if (stall > 0) begin
        out_tready <= 0;
        stall--;
      end else begin
        out_tready <= 1;
      end
    end
  end

  initial begin
    wait (send_done);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("tb_page_fault_lru_frame_manager: done, clean");
    else
      $display("tb_page_fault_lru_frame_manager: done, errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_page_fault_lru_frame_manager: done, errors");
    $finish;
  end
endmodule
